[rtl/lcs_pkg.sv]
// shared types and constants of the led cube layer scanner
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    // cube geometry
    localparam int LEDS_PER_LAYER = 12;
    localparam int NUM_LAYERS     = 2;
    localparam int LED_W          = 4;
    localparam int LEVEL_W        = 3;
    localparam int COLOUR_W       = 2;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // colour codes
    localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_BLUE  = 2'd2;

    // classified request passed from front to back
    typedef struct packed {
        logic               is_tick;
        logic               layer;
        logic [LED_W-1:0]   led;
        logic [LEVEL_W-1:0] level;
    } t_op;

endpackage

`default_nettype wire

[rtl/lcs_front.sv]
// front end: accepts requests, drops bad colours, saturates levels
`timescale 1ns / 1ps
`default_nettype none

module lcs_front #(
    parameter int PWM_STEPS = 6
) (
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_cmd,
    input  wire logic                         i_layer,
    input  wire logic                         i_row,
    input  wire logic                         i_column,
    input  wire logic [lcs_pkg::COLOUR_W-1:0] i_colour,
    input  wire logic [lcs_pkg::LEVEL_W-1:0]  i_level,
    output logic                              o_push,
    output lcs_pkg::t_op                      o_op,
    input  wire logic                         i_full
);
    import lcs_pkg::*;

    localparam int SAT_W = LEVEL_W + 1;
    localparam logic [SAT_W-1:0] STEPS_EXT = SAT_W'(PWM_STEPS);

    logic drop;
    logic over;

    // a write to a colour beyond blue has no effect
    always_comb begin
        drop = (i_cmd == CMD_WRITE) &&
               (i_colour != COLOUR_RED) && (i_colour != COLOUR_GREEN) &&
               (i_colour != COLOUR_BLUE);
        over = {1'b0, i_level} > STEPS_EXT;
    end

    // classify and build the queue entry
    always_comb begin
        o_ready       = !i_full;
        o_push        = i_valid && !i_full && !drop;
        o_op.is_tick  = (i_cmd == CMD_TICK);
        o_op.layer    = i_layer;
        o_op.led      = {i_colour, i_row, i_column};
        o_op.level    = over ? STEPS_EXT[LEVEL_W-1:0] : i_level;
    end

endmodule

`default_nettype wire

[rtl/lcs_queue.sv]
// short queue of classified requests between front and back
`timescale 1ns / 1ps
`default_nettype none

module lcs_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire lcs_pkg::t_op i_op,
    output logic              o_full,
    output logic              o_nempty,
    input  wire logic         i_pop,
    output lcs_pkg::t_op      o_op
);
    import lcs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    // pointer and count update
    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && o_nempty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // status and head entry
    always_comb begin
        o_full   = (r_count == CNT_W'(QUEUE_DEPTH));
        o_nempty = (r_count != '0);
        o_op     = r_mem[r_rd_ptr];
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push not counted");

endmodule

`default_nettype wire

[rtl/lcs_back.sv]
// back end: intensity store, scan counters and the output register
`timescale 1ns / 1ps
`default_nettype none

module lcs_back #(
    parameter int PWM_STEPS = 6
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_nempty,
    input  wire lcs_pkg::t_op i_op,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [7:0]        o_first_byte,
    output logic [7:0]        o_second_byte,
    output logic [1:0]        o_layer_enable
);
    import lcs_pkg::*;

    localparam int SLICE_W = (PWM_STEPS > 1) ? $clog2(PWM_STEPS) : 1;
    localparam int CMP_W   = (SLICE_W > LEVEL_W) ? SLICE_W : LEVEL_W;
    localparam logic [SLICE_W-1:0] SLICE_LAST = SLICE_W'(PWM_STEPS - 1);

    logic [LEVEL_W-1:0]        r_store [NUM_LAYERS][LEDS_PER_LAYER];
    logic [SLICE_W-1:0]        r_slice, n_slice;
    logic                      r_layer, n_layer;
    logic                      r_valid, n_valid;
    logic [7:0]                r_first, n_first;
    logic [7:0]                r_second, n_second;
    logic [1:0]                r_enable, n_enable;
    logic [LEDS_PER_LAYER-1:0] lit;
    logic                      out_free;
    logic                      do_tick;
    logic                      do_write;

    // twelve compares of the shown layer against the current slice
    always_comb begin
        for (int n = 0; n < LEDS_PER_LAYER; n++) begin
            lit[n] = CMP_W'(r_store[r_layer][n]) > CMP_W'(r_slice);
        end
    end

    // pop control: writes always go, ticks wait for a free output slot
    always_comb begin
        out_free = !r_valid || i_ready;
        o_pop    = i_nempty && (!i_op.is_tick || out_free);
        do_tick  = o_pop && i_op.is_tick;
        do_write = o_pop && !i_op.is_tick;
    end

    // next output and counter state
    always_comb begin
        n_valid  = r_valid && !i_ready;
        n_first  = r_first;
        n_second = r_second;
        n_enable = r_enable;
        n_slice  = r_slice;
        n_layer  = r_layer;
        if (do_tick) begin
            n_valid = 1'b1;
            for (int n = 0; n < 8; n++) begin
                n_second[7-n] = lit[n];
            end
            for (int n = 8; n < LEDS_PER_LAYER; n++) begin
                n_first[15-n] = lit[n];
            end
            n_first[3:0] = '0;
            n_enable     = r_layer ? 2'b10 : 2'b01;
            if (r_slice == SLICE_LAST) begin
                n_slice = '0;
                n_layer = !r_layer;
            end else begin
                n_slice = r_slice + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slice <= '0;
            r_layer <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_slice <= n_slice;
            r_layer <= n_layer;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
        r_enable <= n_enable;
    end

    // intensity store, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LAYERS; l++) begin
                for (int n = 0; n < LEDS_PER_LAYER; n++) begin
                    r_store[l][n] <= '0;
                end
            end
        end else if (do_write) begin
            r_store[i_op.layer][i_op.led] <= i_op.level;
        end
    end

    always_comb begin
        o_valid        = r_valid;
        o_first_byte   = r_first;
        o_second_byte  = r_second;
        o_layer_enable = r_enable;
    end

    a_slice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slice <= SLICE_LAST)
        else $error("slice counter out of range");

    a_layer_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_layer != $past(r_layer)) |-> (r_slice == '0))
        else $error("layer changed without slice wrap");

    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot(r_enable))
        else $error("layer enable not one-hot");

    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_nempty && i_op.is_tick && r_valid && !i_ready) |-> !o_pop)
        else $error("tick popped into a stalled output");

endmodule

`default_nettype wire

[rtl/led_cube_layer_pwm_scanner.sv]
// top level of the led cube layer pwm scanner
// Scan driver for a 2x2x2 RGB LED cube with layer multiplexing and
// thermometer PWM. One input channel (valid/ready) carries requests:
// cmd 0 writes one intensity (layer, row, column, colour, level; level
// above PWM_STEPS is stored as PWM_STEPS, colour 3 is ignored), cmd 1 is
// a scan tick. Each tick gives one result on the output channel: two
// bytes in send order and a one-hot layer enable; writes give none.
// Requests are decoded in the front end and held in a two-entry queue;
// the back end applies writes and builds the 12 LED bits of a tick with
// parallel compares against the slice counter. An accepted tick is
// written into the queue, then into the output register. While the
// receiver takes each result, one request per cycle is sustained, set
// by the single output register and the queue pop. When the receiver
// stalls, the result holds, a tick at the queue head waits (writes
// ahead of it still drain) and the queue fills; input ready drops once
// two requests are waiting. Synchronous reset clears the intensity
// store, both counters, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module led_cube_layer_pwm_scanner #(
    parameter int PWM_STEPS = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_cmd,
    input  wire logic                         i_layer,
    input  wire logic                         i_row,
    input  wire logic                         i_column,
    input  wire logic [lcs_pkg::COLOUR_W-1:0] i_colour,
    input  wire logic [lcs_pkg::LEVEL_W-1:0]  i_level,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [7:0]                        o_first_byte,
    output logic [7:0]                        o_second_byte,
    output logic [1:0]                        o_layer_enable
);
    import lcs_pkg::*;

    logic push;
    logic full;
    logic nempty;
    logic pop;
    t_op  front_op;
    t_op  head_op;

    // request decode
    lcs_front #(
        .PWM_STEPS(PWM_STEPS)
    ) u_front (
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_cmd    (i_cmd),
        .i_layer  (i_layer),
        .i_row    (i_row),
        .i_column (i_column),
        .i_colour (i_colour),
        .i_level  (i_level),
        .o_push   (push),
        .o_op     (front_op),
        .i_full   (full)
    );

    // decoupling queue
    lcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (front_op),
        .o_full   (full),
        .o_nempty (nempty),
        .i_pop    (pop),
        .o_op     (head_op)
    );

    // store, counters and output
    lcs_back #(
        .PWM_STEPS(PWM_STEPS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nempty       (nempty),
        .i_op           (head_op),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_first_byte   (o_first_byte),
        .o_second_byte  (o_second_byte),
        .o_layer_enable (o_layer_enable)
    );

endmodule

`default_nettype wire
